@@ rtl/core/bc_pkg.sv @@
// Shared types, codes and defaults for the book cipher codec.
`default_nettype none

package bc_pkg;

  localparam int BOOK_ROWS_DEF = 64;
  localparam int ROW_CHARS_DEF = 128;

  localparam int OP_W   = 2;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_ENC  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEC  = 2'd2;

  localparam logic [ST_W-1:0] STAT_OK        = 2'd0;
  localparam logic [ST_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] STAT_BLANK     = 2'd2;
  localparam logic [ST_W-1:0] STAT_EMPTY     = 2'd3;

  localparam logic [CHAR_W-1:0] BLANK_MARK = 8'h5F;

  typedef enum logic [2:0] {
    RES_LOAD  = 3'd0,
    RES_BLANK = 3'd1,
    RES_DEC   = 3'd2,
    RES_FOUND = 3'd3,
    RES_MISS  = 3'd4
  } res_kind_t;

  typedef struct packed {
    logic      latch;
    logic      clr_step;
    logic      ld_wr;
    logic      scan_init;
    logic      scan_run;
    logic      emit;
    res_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_hit;
    logic scan_last;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/bc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire  logic                   clk,
  input  wire  logic                   we,
  input  wire  logic [AW-1:0]          waddr,
  input  wire  logic [WIDTH-1:0]       wdata,
  input  wire  logic [AW-1:0]          raddr,
  output logic       [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/bc_ctrl.sv @@
// Controller state machine of the book cipher codec.
`default_nettype none

module bc_ctrl (
  input  wire  logic                      clk,
  input  wire  logic                      rst_n,
  input  wire  logic                      start,
  input  wire  logic [bc_pkg::OP_W-1:0]   in_operation,
  input  wire  logic                      in_is_blank,
  input  wire  bc_pkg::dp_sts_t           sts,
  output logic                            busy,
  output bc_pkg::dp_cmd_t                 cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_LD_RD  = 7'b0000100,
    ST_LD_WR  = 7'b0001000,
    ST_DC_RD  = 7'b0010000,
    ST_DC_CHK = 7'b0100000,
    ST_SCAN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.kind      = bc_pkg::RES_LOAD;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          unique case (in_operation)
            bc_pkg::OP_LOAD: state_nxt = ST_LD_RD;
            bc_pkg::OP_ENC: begin
              cmd.scan_init = 1'b1;
              state_nxt     = ST_SCAN;
            end
            bc_pkg::OP_DEC: begin
              if (in_is_blank) begin
                cmd.emit = 1'b1;
                cmd.kind = bc_pkg::RES_BLANK;
              end else begin
                state_nxt = ST_DC_RD;
              end
            end
            default: state_nxt = ST_IDLE;  // drop the unused operation
          endcase
        end
      end
      ST_LD_RD: state_nxt = ST_LD_WR;
      ST_LD_WR: begin
        cmd.ld_wr = 1'b1;
        cmd.emit  = 1'b1;
        cmd.kind  = bc_pkg::RES_LOAD;
        state_nxt = ST_IDLE;
      end
      ST_DC_RD: state_nxt = ST_DC_CHK;
      ST_DC_CHK: begin
        cmd.emit  = 1'b1;
        cmd.kind  = bc_pkg::RES_DEC;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        priority if (sts.scan_hit) begin
          cmd.emit  = 1'b1;
          cmd.kind  = bc_pkg::RES_FOUND;
          state_nxt = ST_IDLE;
        end else if (sts.scan_last) begin
          cmd.emit  = 1'b1;
          cmd.kind  = bc_pkg::RES_MISS;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

`ifndef SYNTHESIS
  a_enc_enters_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start && in_operation == bc_pkg::OP_ENC) |=> state_r == ST_SCAN)
    else $error("encrypt item did not start a scan");
  a_emit_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> state_r == ST_IDLE)
    else $error("result emitted without returning to idle");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (!cmd.scan_run && !cmd.clr_step && !cmd.ld_wr))
    else $error("datapath command active while idle");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bc_dp.sv @@
// Datapath: key book RAM, row scan pipeline and result registers.
`default_nettype none

module bc_dp #(
  parameter int BOOK_ROWS = bc_pkg::BOOK_ROWS_DEF,
  parameter int ROW_CHARS = bc_pkg::ROW_CHARS_DEF
) (
  input  wire  logic                        clk,
  input  wire  logic                        rst_n,
  input  wire  bc_pkg::dp_cmd_t             cmd,
  output bc_pkg::dp_sts_t                   sts,
  input  wire  logic [bc_pkg::ROW_W-1:0]    in_row,
  input  wire  logic [bc_pkg::COL_W-1:0]    in_col,
  input  wire  logic [bc_pkg::CHAR_W-1:0]   in_char_in,
  output logic                              out_valid,
  output logic       [bc_pkg::ST_W-1:0]     out_status,
  output logic       [bc_pkg::ROW_W-1:0]    out_row_out,
  output logic       [bc_pkg::COL_W-1:0]    out_col_out,
  output logic       [bc_pkg::CHAR_W-1:0]   out_char_out
);

  localparam int RAW    = (BOOK_ROWS > 1) ? $clog2(BOOK_ROWS) : 1;
  localparam int CAW    = (ROW_CHARS > 1) ? $clog2(ROW_CHARS) : 1;
  localparam int CNT_W  = RAW + 1;
  localparam int CW     = bc_pkg::CHAR_W;
  localparam int CHRS_W = ROW_CHARS * CW;
  localparam int WORD_W = CHRS_W + ROW_CHARS;

  // latched item
  logic [bc_pkg::ROW_W-1:0]  op_row_r;
  logic [bc_pkg::COL_W-1:0]  op_col_r;
  logic [CW-1:0]             op_char_r;

  // row counter for clearing and scanning
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             issue;

  // scan pipeline
  logic                 rd_v_r, rd_v_nxt;
  logic [RAW-1:0]       rd_row_r;
  logic                 m_v_r, m_v_nxt;
  logic [RAW-1:0]       m_row_r;
  logic [ROW_CHARS-1:0] match_r, match_nxt;

  // RAM
  logic              ram_we;
  logic [RAW-1:0]    ram_waddr, ram_raddr, row_idx;
  logic [WORD_W-1:0] ram_wdata, ram_rdata, ld_word;

  logic           in_range;
  logic [CAW-1:0] col_idx, hit_col;
  logic           dec_pres;
  logic [CW-1:0]  dec_char;

  logic                     out_valid_r;
  logic [bc_pkg::ST_W-1:0]  out_status_r, out_status_nxt;
  logic [bc_pkg::ROW_W-1:0] out_row_r, out_row_nxt;
  logic [bc_pkg::COL_W-1:0] out_col_r, out_col_nxt;
  logic [CW-1:0]            out_char_r, out_char_nxt;

  function automatic logic [CAW-1:0] first_hit(input logic [ROW_CHARS-1:0] m);
    logic [CAW-1:0] idx;
    idx = '0;
    for (int i = ROW_CHARS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = CAW'(i);
      end
    end
    return idx;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_row_r  <= in_row;
      op_col_r  <= in_col;
      op_char_r <= in_char_in;
    end
  end

  assign row_idx  = RAW'(op_row_r);
  assign col_idx  = CAW'(op_col_r);
  assign in_range = (int'(op_row_r) < BOOK_ROWS) && (int'(op_col_r) < ROW_CHARS);

  assign issue = (cnt_r < CNT_W'(BOOK_ROWS));

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.scan_init) begin
      cnt_nxt = '0;
    end else if (cmd.clr_step || (cmd.scan_run && issue)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  assign rd_v_nxt = cmd.scan_run && issue;
  assign m_v_nxt  = cmd.scan_run && rd_v_r;

  always_comb begin
    for (int i = 0; i < ROW_CHARS; i++) begin
      match_nxt[i] = ram_rdata[CHRS_W + i] && (ram_rdata[i*CW +: CW] == op_char_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rd_v_r <= 1'b0;
      m_v_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      rd_v_r <= rd_v_nxt;
      m_v_r  <= m_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_row_r <= cnt_r[RAW-1:0];
    m_row_r  <= rd_row_r;
    match_r  <= match_nxt;
  end

  assign sts.clr_last  = (cnt_r == CNT_W'(BOOK_ROWS - 1));
  assign sts.scan_hit  = m_v_r && (|match_r);
  assign sts.scan_last = m_v_r && (m_row_r == RAW'(BOOK_ROWS - 1));

  // merge the loaded character into the row read back
  always_comb begin
    ld_word = ram_rdata;
    if (in_range) begin
      ld_word[col_idx*CW +: CW]  = op_char_r;
      ld_word[CHRS_W + col_idx]  = 1'b1;
    end
  end

  assign ram_we    = cmd.clr_step || (cmd.ld_wr && in_range);
  assign ram_waddr = cmd.clr_step ? cnt_r[RAW-1:0] : row_idx;
  assign ram_wdata = cmd.clr_step ? '0 : ld_word;
  assign ram_raddr = cmd.scan_run ? cnt_r[RAW-1:0] : row_idx;

  bc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BOOK_ROWS)
  ) u_book (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign dec_pres = in_range ? ram_rdata[CHRS_W + col_idx] : 1'b0;
  assign dec_char = in_range ? ram_rdata[col_idx*CW +: CW] : '0;
  assign hit_col  = first_hit(match_r);

  always_comb begin
    out_status_nxt = bc_pkg::STAT_OK;
    out_row_nxt    = '0;
    out_col_nxt    = '0;
    out_char_nxt   = '0;
    unique case (cmd.kind)
      bc_pkg::RES_LOAD: out_status_nxt = bc_pkg::STAT_OK;
      bc_pkg::RES_BLANK: begin
        out_status_nxt = bc_pkg::STAT_BLANK;
        out_char_nxt   = bc_pkg::BLANK_MARK;
      end
      bc_pkg::RES_DEC: begin
        if (dec_pres) begin
          out_char_nxt = dec_char;
        end else begin
          out_status_nxt = bc_pkg::STAT_EMPTY;
        end
      end
      bc_pkg::RES_FOUND: begin
        out_row_nxt = bc_pkg::ROW_W'(m_row_r);
        out_col_nxt = bc_pkg::COL_W'(hit_col);
      end
      bc_pkg::RES_MISS: out_status_nxt = bc_pkg::STAT_NOT_FOUND;
      default: out_status_nxt = bc_pkg::STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= out_status_nxt;
      out_row_r    <= out_row_nxt;
      out_col_r    <= out_col_nxt;
      out_char_r   <= out_char_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_row_out  = out_row_r;
  assign out_col_out  = out_col_r;
  assign out_char_out = out_char_r;

`ifndef SYNTHESIS
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_run |-> !ram_we)
    else $error("book written during a scan");
  a_match_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    m_v_r |-> $past(rd_v_r))
    else $error("match stage valid without a row read");
  a_hit_only_scanning: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.kind == bc_pkg::RES_FOUND) |-> (cmd.scan_run && sts.scan_hit))
    else $error("found result outside a scan hit");
`endif

endmodule

`default_nettype wire

@@ rtl/core/book_cipher_codec_top.sv @@
// Load and decrypt read the book row, then register the result; a blank decrypt skips the read.
// Encrypt reads one book row per RAM cycle and registers its match flags;
// the first matching row, or a miss after the last row, is then registered as the result.
// One item at a time: busy stays high until the item's result is registered; a blank decrypt never raises it.
// After reset, busy stays high while every row is cleared to empty.
// The receiver cannot stall: out_valid marks each result for one cycle only.
`default_nettype none

module book_cipher_codec_top #(
  parameter int BOOK_ROWS = bc_pkg::BOOK_ROWS_DEF,
  parameter int ROW_CHARS = bc_pkg::ROW_CHARS_DEF
) (
  input  wire  logic                        clk,
  input  wire  logic                        rst_n,
  input  wire  logic                        start,
  output logic                              busy,
  input  wire  logic [bc_pkg::OP_W-1:0]     in_operation,
  input  wire  logic [bc_pkg::ROW_W-1:0]    in_row,
  input  wire  logic [bc_pkg::COL_W-1:0]    in_col,
  input  wire  logic [bc_pkg::CHAR_W-1:0]   in_char_in,
  input  wire  logic                        in_is_blank,
  output logic                              out_valid,
  output logic       [bc_pkg::ST_W-1:0]     out_status,
  output logic       [bc_pkg::ROW_W-1:0]    out_row_out,
  output logic       [bc_pkg::COL_W-1:0]    out_col_out,
  output logic       [bc_pkg::CHAR_W-1:0]   out_char_out
);

  bc_pkg::dp_cmd_t cmd;
  bc_pkg::dp_sts_t sts;

  bc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .in_is_blank  (in_is_blank),
    .sts          (sts),
    .busy         (busy),
    .cmd          (cmd)
  );

  bc_dp #(
    .BOOK_ROWS (BOOK_ROWS),
    .ROW_CHARS (ROW_CHARS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_char_in   (in_char_in),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_row_out  (out_row_out),
    .out_col_out  (out_col_out),
    .out_char_out (out_char_out)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the book cipher codec: directed table, then random items.
`default_nettype none

module testbench;
  import bc_pkg::*;

  localparam int BOOK_ROWS  = BOOK_ROWS_DEF;
  localparam int ROW_CHARS  = ROW_CHARS_DEF;
  localparam int BOOK_SIZE  = BOOK_ROWS * ROW_CHARS;
  localparam int PHASE_ITEMS = 288;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] ch;
    logic              blank;
  } token_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] ch;
  } reply_t;

  typedef struct packed {
    token_t tok;
    logic   pinned;
    reply_t reply;
  } plan_row_t;

  localparam reply_t NO_REPLY = '{STAT_OK, 6'd0, 7'd0, 8'h00};

  localparam plan_row_t DIRECTED [25] = '{
    '{'{OP_DEC,    6'd0,  7'd0,   8'h00, 1'b0}, 1'b1, '{STAT_EMPTY, 6'd0, 7'd0, 8'h00}},
    '{'{OP_ENC,    6'd0,  7'd0,   8'h41, 1'b0}, 1'b1, '{STAT_NOT_FOUND, 6'd0, 7'd0, 8'h00}},
    '{'{OP_DEC,    6'd63, 7'd127, 8'h00, 1'b1}, 1'b1, '{STAT_BLANK, 6'd0, 7'd0, BLANK_MARK}},
    '{'{OP_UNUSED, 6'd0,  7'd0,   8'h00, 1'b0}, 1'b0, NO_REPLY},
    '{'{OP_LOAD,   6'd63, 7'd127, 8'hFF, 1'b1}, 1'b1, '{STAT_OK, 6'd0, 7'd0, 8'h00}},
    '{'{OP_ENC,    6'd0,  7'd0,   8'hFF, 1'b0}, 1'b1, '{STAT_OK, 6'd63, 7'd127, 8'h00}},
    '{'{OP_LOAD,   6'd0,  7'd0,   8'h00, 1'b0}, 1'b1, '{STAT_OK, 6'd0, 7'd0, 8'h00}},
    '{'{OP_ENC,    6'd63, 7'd127, 8'h00, 1'b1}, 1'b1, '{STAT_OK, 6'd0, 7'd0, 8'h00}},
    '{'{OP_DEC,    6'd63, 7'd127, 8'h00, 1'b0}, 1'b1, '{STAT_OK, 6'd0, 7'd0, 8'hFF}},
    '{'{OP_DEC,    6'd0,  7'd0,   8'hFF, 1'b0}, 1'b1, '{STAT_OK, 6'd0, 7'd0, 8'h00}},
    '{'{OP_LOAD,   6'd5,  7'd64,  8'h4B, 1'b0}, 1'b0, NO_REPLY},
    '{'{OP_LOAD,   6'd2,  7'd3,   8'h4B, 1'b1}, 1'b0, NO_REPLY},
    '{'{OP_ENC,    6'd0,  7'd0,   8'h4B, 1'b0}, 1'b1, '{STAT_OK, 6'd2, 7'd3, 8'h00}},
    '{'{OP_LOAD,   6'd0,  7'd0,   8'h4B, 1'b0}, 1'b0, NO_REPLY},
    '{'{OP_ENC,    6'd0,  7'd0,   8'h4B, 1'b0}, 1'b1, '{STAT_OK, 6'd0, 7'd0, 8'h00}},
    '{'{OP_ENC,    6'd0,  7'd0,   8'h00, 1'b0}, 1'b1, '{STAT_NOT_FOUND, 6'd0, 7'd0, 8'h00}},
    '{'{OP_DEC,    6'd5,  7'd64,  8'h00, 1'b0}, 1'b0, NO_REPLY},
    '{'{OP_DEC,    6'd1,  7'd1,   8'h00, 1'b0}, 1'b1, '{STAT_EMPTY, 6'd0, 7'd0, 8'h00}},
    '{'{OP_DEC,    6'd0,  7'd0,   8'h00, 1'b1}, 1'b1, '{STAT_BLANK, 6'd0, 7'd0, BLANK_MARK}},
    '{'{OP_UNUSED, 6'd63, 7'd127, 8'hFF, 1'b1}, 1'b0, NO_REPLY},
    '{'{OP_LOAD,   6'd10, 7'd10,  8'h5F, 1'b0}, 1'b0, NO_REPLY},
    '{'{OP_ENC,    6'd0,  7'd0,   8'h5F, 1'b0}, 1'b1, '{STAT_OK, 6'd10, 7'd10, 8'h00}},
    '{'{OP_DEC,    6'd10, 7'd10,  8'hAA, 1'b0}, 1'b0, NO_REPLY},
    '{'{OP_ENC,    6'd0,  7'd0,   8'h80, 1'b0}, 1'b0, NO_REPLY},
    '{'{OP_ENC,    6'd63, 7'd127, 8'hFF, 1'b1}, 1'b0, NO_REPLY}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   in_operation;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [CHAR_W-1:0] in_char_in;
  logic              in_is_blank;
  logic              out_valid;
  logic [ST_W-1:0]   out_status;
  logic [ROW_W-1:0]  out_row_out;
  logic [COL_W-1:0]  out_col_out;
  logic [CHAR_W-1:0] out_char_out;

  // Predictor copy of the key book
  logic [CHAR_W-1:0] key_chars [BOOK_SIZE];
  bit                key_present [BOOK_SIZE];
  logic [ROW_W+COL_W-1:0] loaded_spots [$];

  reply_t pending_replies [$];
  int     mismatch_count = 0;

  book_cipher_codec_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_char_in   (in_char_in),
    .in_is_blank  (in_is_blank),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_row_out  (out_row_out),
    .out_col_out  (out_col_out),
    .out_char_out (out_char_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(20 * 1000000);
    $display("FAIL");
    $finish;
  end

  // Apply one item to the key book and return the reply it should produce, if any.
  function automatic bit codec_predict(input token_t t, output reply_t r);
    int  idx;
    bit  hit;
    bit  in_range;
    r        = NO_REPLY;
    in_range = (int'(t.row) < BOOK_ROWS) && (int'(t.col) < ROW_CHARS);
    idx      = int'(t.row) * ROW_CHARS + int'(t.col);
    case (t.op)
      OP_LOAD: begin
        if (in_range) begin
          key_chars[idx]   = t.ch;
          key_present[idx] = 1'b1;
          loaded_spots.insert(loaded_spots.size(), {t.row, t.col});
        end
        return 1'b1;
      end
      OP_ENC: begin
        hit = 1'b0;
        for (int i = 0; i < BOOK_ROWS && !hit; i++) begin
          for (int j = 0; j < ROW_CHARS && !hit; j++) begin
            if (key_present[i * ROW_CHARS + j] && key_chars[i * ROW_CHARS + j] == t.ch) begin
              hit   = 1'b1;
              r.row = ROW_W'(i);
              r.col = COL_W'(j);
            end
          end
        end
        if (!hit) r.status = STAT_NOT_FOUND;
        return 1'b1;
      end
      OP_DEC: begin
        if (t.blank) begin
          r.status = STAT_BLANK;
          r.ch     = BLANK_MARK;
        end else if (in_range && key_present[idx]) begin
          r.ch = key_chars[idx];
        end else begin
          r.status = STAT_EMPTY;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Present one item, hold it until taken, then queue what it should produce.
  task automatic issue_item(input token_t t, input bit pinned, input reply_t pin_reply,
                            input int gap);
    reply_t r;
    bit     has_reply;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_operation <= t.op;
    in_row       <= t.row;
    in_col       <= t.col;
    in_char_in   <= t.ch;
    in_is_blank  <= t.blank;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    has_reply = codec_predict(t, r);
    if (has_reply) pending_replies.insert(pending_replies.size(), pinned ? pin_reply : r);
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_valid) begin
      got = '{out_status, out_row_out, out_col_out, out_char_out};
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d row %0d col %0d char %h",
                   got.status, got.row, got.col, got.ch);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp status %0d row %0d col %0d char %h, got %0d %0d %0d %h",
                     want.status, want.row, want.col, want.ch,
                     got.status, got.row, got.col, got.ch);
        end
      end
    end
  end

  initial begin
    int     idle_pct [4];
    int     sent;
    int     gap;
    int     roll;
    int     waited;
    token_t t;
    logic [ROW_W+COL_W-1:0] spot;

    idle_pct = '{0, 57, 0, 37};
    for (int i = 0; i < BOOK_SIZE; i++) begin
      key_chars[i]   = '0;
      key_present[i] = 1'b0;
    end
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_operation <= OP_LOAD;
    in_row       <= '0;
    in_col       <= '0;
    in_char_in   <= '0;
    in_is_blank  <= 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[k])
      issue_item(DIRECTED[k].tok, DIRECTED[k].pinned, DIRECTED[k].reply, k % 3);

    for (int ph = 0; ph < 4; ph++) begin
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        t.row   = ROW_W'($urandom_range(BOOK_ROWS - 1));
        t.col   = COL_W'($urandom_range(ROW_CHARS - 1));
        t.ch    = CHAR_W'($urandom_range(255));
        t.blank = 1'($urandom_range(1));
        // Small alphabet half the time so first-match order matters
        if ($urandom_range(1) == 0) t.ch = CHAR_W'($urandom_range(8'h68, 8'h61));
        roll = $urandom_range(99);
        if (roll < 30) begin
          t.op = OP_LOAD;
        end else if (roll < 65) begin
          t.op = OP_ENC;
          if (loaded_spots.size() > 0 && $urandom_range(9) < 7) begin
            spot = loaded_spots[$urandom_range(loaded_spots.size() - 1)];
            t.ch = key_chars[int'(spot[ROW_W+COL_W-1:COL_W]) * ROW_CHARS
                             + int'(spot[COL_W-1:0])];
          end
        end else if (roll < 95) begin
          t.op    = OP_DEC;
          t.blank = ($urandom_range(9) == 0);
          if (loaded_spots.size() > 0 && $urandom_range(9) < 6) begin
            spot  = loaded_spots[$urandom_range(loaded_spots.size() - 1)];
            t.row = spot[ROW_W+COL_W-1:COL_W];
            t.col = spot[COL_W-1:0];
          end
        end else begin
          t.op = OP_UNUSED;
        end
        gap = ($urandom_range(99) < idle_pct[ph]) ? $urandom_range(8, 1) : 0;
        issue_item(t, 1'b0, NO_REPLY, gap);
        if (t.op != OP_UNUSED) sent++;
      end
    end

    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (pending_replies.size() != 0 && waited < 4 * BOOK_ROWS + 100) begin
      @(posedge clk);
      waited++;
    end
    // Drain: allow a stray late result to show up
    repeat (BOOK_ROWS + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ book_cipher_codec_top.f @@
rtl/core/bc_pkg.sv
rtl/core/bc_ram.sv
rtl/core/bc_ctrl.sv
rtl/core/bc_dp.sv
rtl/core/book_cipher_codec_top.sv
tb/testbench.sv
